// ===== sv/fbrp_pkg.sv =====
// Shared types, constants and helper functions for the frame buffer rotation block.
`timescale 1ns / 1ps

package fbrp_pkg;

  localparam int NUM_FRAMES   = 4;
  localparam int IDX_W        = 2;
  localparam int AGE_BITS_DEF = 31;
  localparam int FC_W         = 3;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [FC_W-1:0]  fc_t;

  localparam fc_t  FC_RESET  = 3'd4;
  localparam fc_t  FC_TRIPLE = 3'd3;
  localparam fc_t  FC_QUAD   = 3'd4;
  localparam idx_t IDX_LAST  = idx_t'(NUM_FRAMES - 1);
  localparam idx_t DRAW_RST  = 2'd1;

  localparam logic OP_VIEW = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  typedef enum logic [1:0] {
    MODE_SINGLE,
    MODE_TRIPLE,
    MODE_QUAD
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_BLEND,
    ST_STAMP,
    ST_DONE
  } fbrp_state_e;

  typedef struct packed {
    logic clr;
    logic stamp;
    idx_t stamp_idx;
    idx_t rd_idx;
  } age_ctrl_t;

  function automatic mode_e mode_of(fc_t fc);
    mode_e m;
    m = MODE_SINGLE;
    if (fc == FC_TRIPLE) begin
      m = MODE_TRIPLE;
    end else if (fc == FC_QUAD) begin
      m = MODE_QUAD;
    end
    return m;
  endfunction

  // Returns the store among the first three that differs from both a and b.
  function automatic idx_t third_of(idx_t a, idx_t b);
    idx_t r;
    case (a)
      2'd0: r = (b == 2'd1) ? 2'd2 : 2'd1;
      2'd1: r = (b == 2'd2) ? 2'd0 : 2'd2;
      default: r = (b == 2'd0) ? 2'd1 : 2'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/fbrp_cmp.sv =====
// Shared magnitude comparator used for every age comparison of the sequencer.
`timescale 1ns / 1ps

module fbrp_cmp
  import fbrp_pkg::*;
#(
  parameter int AGE_BITS = AGE_BITS_DEF
) (
  input  logic [AGE_BITS-1:0] a_i,
  input  logic [AGE_BITS-1:0] b_i,
  input  logic                lt_sel_i,
  output logic                hit_o
);

  always_comb begin
    if (lt_sel_i) begin
      hit_o = (a_i < b_i);
    end else begin
      hit_o = (a_i > b_i);
    end
  end

endmodule

// ===== sv/fbrp_age_file.sv =====
// Per-store age stamps with the saturating age counter and one read port.
`timescale 1ns / 1ps

module fbrp_age_file
  import fbrp_pkg::*;
#(
  parameter int AGE_BITS = AGE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  age_ctrl_t           ctrl_i,
  output logic [AGE_BITS-1:0] rd_age_o
);

  logic [AGE_BITS-1:0] age_q [NUM_FRAMES];
  logic [AGE_BITS-1:0] ctr_q;
  logic [AGE_BITS-1:0] ctr_d;

  assign ctr_d    = (&ctr_q) ? ctr_q : ctr_q + 1'b1;
  assign rd_age_o = age_q[ctrl_i.rd_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q <= '0;
    end else if (ctrl_i.stamp) begin
      ctr_q <= ctr_d;
    end
  end

  for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_age
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        age_q[g] <= '0;
      end else if (ctrl_i.clr) begin
        age_q[g] <= '0;
      end else if (ctrl_i.stamp && (ctrl_i.stamp_idx == idx_t'(g))) begin
        age_q[g] <= ctr_d;
      end
    end
  end

  a_ctr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.stamp |=> (ctr_q != '0))
    else $error("Age counter is zero after a stamp.");

  a_ctr_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (ctr_q >= $past(ctr_q)))
    else $error("Age counter went backwards.");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clr |=> (age_q[0] == '0) && (age_q[1] == '0) && (age_q[2] == '0)
                   && (age_q[3] == '0))
    else $error("Age stamps not cleared.");

endmodule

// ===== sv/frame_buffer_rotation_policy.sv =====
// Top level of the frame buffer rotation block: sequencer, indices and output register.
//
// Channel  | Direction | Signals                          | Content
// s_axis   | in        | tvalid tready tdata[7:0] tuser   | tdata: mix_frames; tuser: op
// m_axis   | out       | tvalid tready tdata[7:0] tuser   | tdata: frame_index, second_index
// cfg      | in        | cfg_we_i cfg_wdata_i[2:0]        | frame_count
//
// The time from acceptance to the output register is set by the single comparator, which
// steps through the four stores one per cycle (quad view with blending is the longest). The
// block takes no new beat until the current one is in the output register.
// The output register holds a result while m_axis_tready is low, and a new beat may be
// accepted meanwhile. Reset clears all ages and the counter, sets the view index to zero and
// the draw index to one, and selects quad mode.
`timescale 1ns / 1ps

module frame_buffer_rotation_policy
  import fbrp_pkg::*;
#(
  parameter int AGE_BITS = AGE_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [7:0]      s_axis_tdata,   // [0] mix_frames, [7:1] zero
  input  logic [0:0]      s_axis_tuser,   // [0] op
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [1:0] frame_index, [3:2] second_index, [7:4] zero
  output logic [0:0]      m_axis_tuser,   // [0] blend_valid
  input  logic            cfg_we_i,
  input  logic [FC_W-1:0] cfg_wdata_i
);

  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  fbrp_state_e state_q, state_d;
  fc_t         fc_q, fc_d;
  idx_t        view_q, view_d;
  idx_t        draw_q, draw_d;
  logic        op_q, op_d;
  logic        mix_q, mix_d;
  idx_t        idx_q, idx_d;
  logic [AGE_BITS-1:0] best_q, best_d;
  idx_t        sel_q, sel_d;
  idx_t        sec_q, sec_d;
  logic        bval_q, bval_d;
  logic        out_valid_q, out_valid_d;
  idx_t        out_frame_q, out_frame_d;
  idx_t        out_sec_q, out_sec_d;
  logic        out_bval_q, out_bval_d;

  age_ctrl_t           ctrl;
  logic [AGE_BITS-1:0] rd_age;
  logic                hit;
  mode_e               mode;
  logic                accept;
  logic                out_free;
  logic                last;
  logic                skip;
  logic                blend_skip;
  idx_t                tri_draw;

  assign mode     = mode_of(fc_q);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign last     = (mode != MODE_QUAD) || (idx_q == IDX_LAST);
  assign skip     = (mode == MODE_QUAD) &&
                    ((op_q == OP_VIEW) ? (idx_q == draw_q) : (idx_q == view_q));
  assign blend_skip = (idx_q == draw_q) || (idx_q == view_q);
  assign tri_draw = (draw_q != IDX_LAST) ? third_of(draw_q, view_q) : draw_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_sec_q, out_frame_q};
  assign m_axis_tuser  = out_bval_q;

  fbrp_age_file #(
    .AGE_BITS (AGE_BITS)
  ) u_age (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .rd_age_o (rd_age)
  );

  fbrp_cmp #(
    .AGE_BITS (AGE_BITS)
  ) u_cmp (
    .a_i      (rd_age),
    .b_i      (best_q),
    .lt_sel_i (op_q == OP_DRAW),
    .hit_o    (hit)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        case (mode)
          MODE_QUAD: state_d = ST_SCAN;
          MODE_TRIPLE: begin
            if (op_q == OP_DRAW) begin
              state_d = ST_STAMP;
            end else if (view_q != IDX_LAST) begin
              state_d = ST_SCAN;
            end else begin
              state_d = ST_DONE;
            end
          end
          default: state_d = (op_q == OP_VIEW) ? ST_STAMP : ST_DONE;
        endcase
      end
      ST_SCAN: begin
        if (last) begin
          if (op_q == OP_DRAW) begin
            state_d = ST_STAMP;
          end else if ((mode == MODE_QUAD) && mix_q) begin
            state_d = ST_BLEND;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_BLEND: begin
        if (idx_q == IDX_LAST) begin
          state_d = ST_DONE;
        end
      end
      ST_STAMP: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    fc_d           = fc_q;
    view_d         = view_q;
    draw_d         = draw_q;
    op_d           = op_q;
    mix_d          = mix_q;
    idx_d          = idx_q;
    best_d         = best_q;
    sel_d          = sel_q;
    sec_d          = sec_q;
    bval_d         = bval_q;
    out_frame_d    = out_frame_q;
    out_sec_d      = out_sec_q;
    out_bval_d     = out_bval_q;
    out_valid_d    = out_valid_q && !m_axis_tready;
    ctrl.clr       = 1'b0;
    ctrl.stamp     = 1'b0;
    ctrl.stamp_idx = sel_q;
    ctrl.rd_idx    = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d  = s_axis_tuser[0];
          mix_d = s_axis_tdata[0];
        end
      end
      ST_LOAD: begin
        ctrl.rd_idx = view_q;
        sec_d       = '0;
        bval_d      = 1'b0;
        idx_d       = '0;
        best_d      = (op_q == OP_DRAW) ? AGE_MAX : rd_age;
        case (mode)
          MODE_QUAD: sel_d = (op_q == OP_DRAW) ? draw_q : view_q;
          MODE_TRIPLE: begin
            if (op_q == OP_DRAW) begin
              draw_d = tri_draw;
              sel_d  = tri_draw;
            end else begin
              sel_d = view_q;
              idx_d = third_of(view_q, draw_q);
            end
          end
          default: sel_d = '0;
        endcase
      end
      ST_SCAN: begin
        if (!skip && hit) begin
          best_d = rd_age;
          sel_d  = idx_q;
        end
        idx_d = idx_t'(idx_q + 1'b1);
        if (last) begin
          if (op_q == OP_DRAW) begin
            draw_d = sel_d;
          end else begin
            view_d = sel_d;
          end
          best_d = '0;
          idx_d  = '0;
        end
      end
      ST_BLEND: begin
        if (!blend_skip && hit) begin
          best_d = rd_age;
          sec_d  = idx_q;
          bval_d = 1'b1;
        end
        idx_d = idx_t'(idx_q + 1'b1);
      end
      ST_STAMP: begin
        ctrl.stamp = 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_frame_d = sel_q;
          out_sec_d   = sec_q;
          out_bval_d  = bval_q;
        end
      end
      default: begin
      end
    endcase
    if (cfg_we_i) begin
      fc_d     = cfg_wdata_i;
      view_d   = '0;
      draw_d   = '0;
      ctrl.clr = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fc_q        <= FC_RESET;
      view_q      <= '0;
      draw_q      <= DRAW_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fc_q        <= fc_d;
      view_q      <= view_d;
      draw_q      <= draw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    mix_q       <= mix_d;
    idx_q       <= idx_d;
    best_q      <= best_d;
    sel_q       <= sel_d;
    sec_q       <= sec_d;
    bval_q      <= bval_d;
    out_frame_q <= out_frame_d;
    out_sec_q   <= out_sec_d;
    out_bval_q  <= out_bval_d;
  end

  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("Second beat accepted while one is in progress.");

  a_blend_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[3:2] != m_axis_tdata[1:0]))
    else $error("Blend store equals the view store.");

  a_blend_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BLEND) |-> ((fc_q == FC_QUAD) && (op_q == OP_VIEW) && mix_q))
    else $error("Blend scan outside a quad view flip.");

endmodule

// ===== test/frame_buffer_rotation_policy_test.sv =====
// Self-checking testbench for the frame buffer rotation block, with a store-choice predictor.
`timescale 1ns / 1ps

module frame_buffer_rotation_policy_test;
  import fbrp_pkg::*;

  // A narrow age width keeps the stamp values short.
  localparam int AGE_W = 16;

  typedef logic [AGE_W-1:0] age_t;
  localparam age_t AGE_TOP = '1;

  typedef struct packed {
    idx_t frame;
    idx_t second;
    logic blend;
  } pick_t;

  typedef enum logic {
    ROW_SET,
    ROW_BEAT
  } row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    fc_t       fc;
    logic      op;
    logic      mix;
    logic      typed;
    pick_t     want;
  } plan_row_t;

  localparam pick_t PICK_0 = '{frame: 2'd0, second: 2'd0, blend: 1'b0};
  localparam pick_t PICK_1 = '{frame: 2'd1, second: 2'd0, blend: 1'b0};

  localparam plan_row_t PLAN [0:27] = '{
    '{ROW_BEAT, FC_RESET, OP_VIEW, 1'b1, 1'b1, PICK_0},
    '{ROW_BEAT, FC_RESET, OP_DRAW, 1'b0, 1'b1, PICK_1},
    '{ROW_BEAT, FC_RESET, OP_DRAW, 1'b1, 1'b0, PICK_0},
    '{ROW_BEAT, FC_RESET, OP_DRAW, 1'b0, 1'b0, PICK_0},
    '{ROW_BEAT, FC_RESET, OP_VIEW, 1'b1, 1'b0, PICK_0},
    '{ROW_BEAT, FC_RESET, OP_VIEW, 1'b0, 1'b0, PICK_0},
    '{ROW_BEAT, FC_RESET, OP_DRAW, 1'b0, 1'b0, PICK_0},
    '{ROW_BEAT, FC_RESET, OP_VIEW, 1'b1, 1'b0, PICK_0},
    '{ROW_SET,  FC_TRIPLE, OP_VIEW, 1'b0, 1'b0, PICK_0},
    '{ROW_BEAT, FC_TRIPLE, OP_VIEW, 1'b1, 1'b1, PICK_0},
    '{ROW_BEAT, FC_TRIPLE, OP_DRAW, 1'b0, 1'b1, PICK_1},
    '{ROW_BEAT, FC_TRIPLE, OP_VIEW, 1'b0, 1'b0, PICK_0},
    '{ROW_BEAT, FC_TRIPLE, OP_DRAW, 1'b1, 1'b0, PICK_0},
    '{ROW_BEAT, FC_TRIPLE, OP_VIEW, 1'b1, 1'b0, PICK_0},
    '{ROW_BEAT, FC_TRIPLE, OP_DRAW, 1'b0, 1'b0, PICK_0},
    '{ROW_SET,  3'd0, OP_VIEW, 1'b0, 1'b0, PICK_0},
    '{ROW_BEAT, 3'd0, OP_VIEW, 1'b1, 1'b1, PICK_0},
    '{ROW_BEAT, 3'd0, OP_DRAW, 1'b1, 1'b1, PICK_0},
    '{ROW_SET,  3'd7, OP_VIEW, 1'b0, 1'b0, PICK_0},
    '{ROW_BEAT, 3'd7, OP_VIEW, 1'b0, 1'b1, PICK_0},
    '{ROW_BEAT, 3'd7, OP_DRAW, 1'b1, 1'b1, PICK_0},
    '{ROW_SET,  FC_QUAD, OP_VIEW, 1'b0, 1'b0, PICK_0},
    '{ROW_BEAT, FC_QUAD, OP_VIEW, 1'b1, 1'b1, PICK_0},
    '{ROW_BEAT, FC_QUAD, OP_DRAW, 1'b0, 1'b0, PICK_0},
    '{ROW_BEAT, FC_QUAD, OP_DRAW, 1'b0, 1'b0, PICK_0},
    '{ROW_BEAT, FC_QUAD, OP_DRAW, 1'b1, 1'b0, PICK_0},
    '{ROW_BEAT, FC_QUAD, OP_VIEW, 1'b1, 1'b0, PICK_0},
    '{ROW_BEAT, FC_QUAD, OP_VIEW, 1'b1, 1'b0, PICK_0}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic [0:0] s_axis_tuser;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic       cfg_we_i;
  fc_t        cfg_wdata_i;

  age_t  store_age [NUM_FRAMES];
  age_t  age_clock;
  idx_t  show_idx;
  idx_t  paint_idx;
  fc_t   fc_now;
  pick_t pending_picks [$];

  logic quiet = 1'b0;
  int   rx_left = 0;
  int   fail_count = 0;
  int   results_seen = 0;
  int   blend_seen = 0;
  int   writes_done = 0;
  logic [7:0] fc_mask = '0;

  frame_buffer_rotation_policy #(
    .AGE_BITS(AGE_W)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Store among the first three that is neither a nor b; a repeated or out-of-range b
  // falls back to the next store after a.
  function automatic idx_t spare_store(idx_t a, idx_t b);
    if (b != IDX_LAST && b != a) return idx_t'(3 - int'(a) - int'(b));
    return idx_t'((int'(a) + 1) % 3);
  endfunction

  function automatic void stamp_store(idx_t k);
    if (age_clock != AGE_TOP) age_clock++;
    store_age[k] = age_clock;
  endfunction

  function automatic void clear_stores(fc_t fc, idx_t draw_start);
    for (int i = 0; i < NUM_FRAMES; i++) store_age[i] = '0;
    show_idx = '0;
    paint_idx = draw_start;
    fc_now = fc;
  endfunction

  function automatic pick_t choose_store(logic op, logic mix);
    pick_t p;
    age_t  best;
    idx_t  k;
    p = '0;
    if (op == OP_VIEW) begin
      if (fc_now == FC_TRIPLE) begin
        if (show_idx != IDX_LAST) begin
          k = spare_store(show_idx, paint_idx);
          if (store_age[k] > store_age[show_idx]) show_idx = k;
        end
        p.frame = show_idx;
      end else if (fc_now == FC_QUAD) begin
        for (int i = 0; i < NUM_FRAMES; i++) begin
          if (idx_t'(i) != paint_idx && store_age[i] > store_age[show_idx]) show_idx = idx_t'(i);
        end
        p.frame = show_idx;
        if (mix) begin
          best = '0;
          for (int i = 0; i < NUM_FRAMES; i++) begin
            if (idx_t'(i) != paint_idx && idx_t'(i) != show_idx && store_age[i] > best) begin
              best = store_age[i];
              p.second = idx_t'(i);
              p.blend = 1'b1;
            end
          end
        end
      end else begin
        stamp_store('0);
      end
    end else begin
      if (fc_now == FC_TRIPLE) begin
        if (paint_idx != IDX_LAST) paint_idx = spare_store(paint_idx, show_idx);
        stamp_store(paint_idx);
        p.frame = paint_idx;
      end else if (fc_now == FC_QUAD) begin
        best = AGE_TOP;
        for (int i = 0; i < NUM_FRAMES; i++) begin
          if (idx_t'(i) != show_idx && store_age[i] < best) begin
            best = store_age[i];
            paint_idx = idx_t'(i);
          end
        end
        stamp_store(paint_idx);
        p.frame = paint_idx;
      end
    end
    return p;
  endfunction

  task automatic send_beat(logic op, logic mix, logic typed, pick_t want);
    pick_t p;
    int    gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'b0, mix};
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    p = choose_store(op, mix);
    pending_picks.push_back(typed ? want : p);
    gap = quiet ? 0 : idle_span();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_frame_count(fc_t v);
    hold_until_drained();
    repeat (12) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    clear_stores(v, '0);
    writes_done++;
    fc_mask[v] = 1'b1;
  endtask

  task automatic random_beats(int count);
    for (int i = 0; i < count; i++) begin
      send_beat(logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)), 1'b0, PICK_0);
      if ($urandom_range(0, 199) == 0) hold_until_drained();
    end
  endtask

  always @(posedge clk_i) begin
    if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (rx_left > 0) begin
      rx_left <= rx_left - 1;
    end else if ($urandom_range(0, 99) < 60) begin
      m_axis_tready <= 1'b1;
      rx_left <= $urandom_range(0, 8);
    end else begin
      m_axis_tready <= 1'b0;
      rx_left <= idle_span();
    end
  end

  always @(posedge clk_i) begin
    pick_t w;
    pick_t g;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      g = '{frame: m_axis_tdata[1:0], second: m_axis_tdata[3:2], blend: m_axis_tuser[0]};
      results_seen++;
      if (g.blend) blend_seen++;
      if (pending_picks.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("Result %0d arrived with nothing pending", results_seen);
      end else begin
        w = pending_picks.pop_front();
        if (g != w) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("Mismatch at result %0d: expected frame %0d second %0d blend %0d,",
                     results_seen, w.frame, w.second, w.blend,
                     " got frame %0d second %0d blend %0d", g.frame, g.second, g.blend);
          end
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int   r;
    int   n;
    fc_t  v;
    rst_ni = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    clear_stores(FC_RESET, DRAW_RST);
    age_clock = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < $size(PLAN); r++) begin
      if (PLAN[r].kind == ROW_SET) begin
        write_frame_count(PLAN[r].fc);
      end else begin
        send_beat(PLAN[r].op, PLAN[r].mix, PLAN[r].typed, PLAN[r].want);
      end
    end

    n = 0;
    while (n < 1450) begin
      r = $urandom_range(0, 9);
      if (r < 4) v = FC_QUAD;
      else if (r < 7) v = FC_TRIPLE;
      else v = fc_t'($urandom_range(0, 7));
      write_frame_count(v);
      quiet <= ($urandom_range(0, 4) == 0);
      r = $urandom_range(20, 150);
      random_beats(r);
      n += r;
    end

    quiet <= 1'b0;
    write_frame_count(FC_QUAD);
    random_beats(300);
    write_frame_count(FC_TRIPLE);
    random_beats(200);

    hold_until_drained();
    repeat (16) @(posedge clk_i);
    $display("Checked %0d results across %0d frame count writes, values seen %b.",
             results_seen, writes_done, fc_mask);
    $display("Blend reports: %0d; final age stamp: %0d.", blend_seen, age_clock);
    if (fail_count == 0 && pending_picks.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
